[rtl/core/wsrm_pkg.sv]
package wsrm_pkg;

	localparam int RAMP_STEPS = 8;
	localparam int IDX_W      = $clog2(RAMP_STEPS);
	localparam int CUR_W      = $clog2(RAMP_STEPS + 1);
	localparam int SPD_W      = 10;
	localparam int ACC_W      = $clog2(999 * RAMP_STEPS + 1);

	localparam logic [SPD_W-1:0] SPEED_MAX = 10'd999;

	localparam int PROD_W    = 48;
	localparam int NUM_W     = 54;
	localparam int DEN_W     = 36;
	localparam int DIV_STEPS = PROD_W / 2;
	localparam int DCNT_W    = $clog2(DIV_STEPS);
	localparam int QBITS     = 10;
	localparam int QCNT_W    = $clog2(QBITS);

	localparam logic [1:0] FUNC_MEASURE = 2'd0;
	localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
	localparam logic [1:0] FUNC_SEND    = 2'd2;

	localparam logic [1:0] CFG_WINDOW_MS       = 2'd0;
	localparam logic [1:0] CFG_MM_PER_TURN     = 2'd1;
	localparam logic [1:0] CFG_PULSES_PER_TURN = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_MUL,
		ST_DIST,
		ST_SPREP,
		ST_SAT,
		ST_SDIV,
		ST_FINIT,
		ST_FILL,
		ST_EMIT
	} wsrm_state_t;

	typedef struct packed {
		logic accept;
		logic close;
		logic dist_step;
		logic spd_prep;
		logic sat;
		logic spd_step;
		logic fill_init;
		logic fill_step;
		logic emit;
	} wsrm_cmd_t;

	typedef struct packed {
		logic close_hit;
		logic dist_last;
		logic spd_last;
		logic fill_last;
		logic out_free;
	} wsrm_stat_t;

endpackage

[rtl/core/wsrm_if.sv]
interface wsrm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] elapsed_ms;
	logic [15:0] pulse_delta;

	modport source (output valid, output func, output elapsed_ms, output pulse_delta,
		input ready);
	modport sink (input valid, input func, input elapsed_ms, input pulse_delta,
		output ready);
endinterface

interface wsrm_out_if;
	logic        valid;
	logic        ready;
	logic        window_closed;
	logic [9:0]  window_speed;
	logic        shown_valid;
	logic [9:0]  shown_speed;
	logic [31:0] odometer_mm;

	modport source (output valid, output window_closed, output window_speed,
		output shown_valid, output shown_speed, output odometer_mm, input ready);
	modport sink (input valid, input window_closed, input window_speed,
		input shown_valid, input shown_speed, input odometer_mm, output ready);
endinterface

[rtl/core/wsrm_ctrl.sv]
module wsrm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  wsrm_pkg::wsrm_stat_t   stat,
	output wsrm_pkg::wsrm_cmd_t    cmd
);
	import wsrm_pkg::*;

	wsrm_state_t state_q;
	wsrm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = stat.close_hit ? ST_MUL : ST_EMIT;
			end
			ST_MUL:   state_d = ST_DIST;
			ST_DIST: begin
				if (stat.dist_last) state_d = ST_SPREP;
			end
			ST_SPREP: state_d = ST_SAT;
			ST_SAT:   state_d = ST_SDIV;
			ST_SDIV: begin
				if (stat.spd_last) state_d = ST_FINIT;
			end
			ST_FINIT: state_d = ST_FILL;
			ST_FILL: begin
				if (stat.fill_last) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_MUL:   cmd.close     = 1'b1;
			ST_DIST:  cmd.dist_step = 1'b1;
			ST_SPREP: cmd.spd_prep  = 1'b1;
			ST_SAT:   cmd.sat       = 1'b1;
			ST_SDIV:  cmd.spd_step  = 1'b1;
			ST_FINIT: cmd.fill_init = 1'b1;
			ST_FILL:  cmd.fill_step = 1'b1;
			ST_EMIT:  cmd.emit      = stat.out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

[rtl/core/wsrm_datapath.sv]
module wsrm_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wsrm_pkg::wsrm_cmd_t    cmd,
	output wsrm_pkg::wsrm_stat_t   stat,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic [1:0]             func,
	input  logic [15:0]            elapsed_ms,
	input  logic [15:0]            pulse_delta,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   window_closed,
	output logic [9:0]             window_speed,
	output logic                   shown_valid,
	output logic [9:0]             shown_speed,
	output logic [31:0]            odometer_mm
);
	import wsrm_pkg::*;

	logic [15:0] window_ms_q;
	logic [15:0] mm_per_turn_q;
	logic [7:0]  ppt_cfg_q;

	logic [1:0]  func_q;
	logic [31:0] wtime_q;
	logic [31:0] wpulses_q;
	logic [31:0] odo_q;
	logic [31:0] tlat_q;
	logic [7:0]  ppt_q;

	logic [PROD_W-1:0] num_q;
	logic [7:0]        rem_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic [NUM_W-1:0]          nsp_q;
	logic [DEN_W-1:0]          den_q;
	logic [DEN_W+QBITS-2:0]    dsh_q;
	logic [QBITS-1:0]          q_q;
	logic [QCNT_W-1:0]         qcnt_q;
	logic                      ovr_q;
	logic [SPD_W-1:0]          ovr_val_q;

	logic [SPD_W-1:0] prev_q;
	logic [SPD_W-1:0] base_q;
	logic [SPD_W-1:0] dmag_q;
	logic             inc_q;
	logic [ACC_W-1:0] acc_q;
	logic [IDX_W-1:0] fidx_q;
	logic [CUR_W-1:0] cur_q;
	logic [SPD_W-1:0] store_q [RAMP_STEPS];

	logic             res_closed_q;
	logic [SPD_W-1:0] res_wspeed_q;
	logic             res_valid_q;
	logic [SPD_W-1:0] res_shown_q;

	logic             out_valid_q;
	logic             out_closed_q;
	logic [SPD_W-1:0] out_wspeed_q;
	logic             out_svalid_q;
	logic [SPD_W-1:0] out_shown_q;
	logic [31:0]      out_odo_q;

	logic [PROD_W-1:0] num_d;
	logic [7:0]        rem_d;
	logic [8:0]        trial;
	logic [SPD_W-1:0]  spd_final;
	logic [SPD_W-1:0]  ramp_step;
	logic              send_ok;

	// Two quotient bits per cycle; the remainder always stays below the divisor.
	always_comb begin
		rem_d = rem_q;
		num_d = num_q;
		trial = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_d, num_d[PROD_W-1]};
			num_d = {num_d[PROD_W-2:0], 1'b0};
			if (trial >= {1'b0, ppt_q}) begin
				trial    = trial - {1'b0, ppt_q};
				num_d[0] = 1'b1;
			end
			rem_d = trial[7:0];
		end
	end

	assign spd_final = ovr_q ? ovr_val_q : ((q_q > SPEED_MAX) ? SPEED_MAX : q_q);
	assign ramp_step = SPD_W'(acc_q / RAMP_STEPS);
	assign send_ok   = (cur_q < CUR_W'(RAMP_STEPS));

	assign stat.close_hit = ((func_q == FUNC_MEASURE) && (wtime_q >= {16'd0, window_ms_q}))
		|| (func_q == FUNC_TIMEOUT);
	assign stat.dist_last = (dcnt_q == DCNT_W'(DIV_STEPS - 1));
	assign stat.spd_last  = (qcnt_q == QCNT_W'(QBITS - 1));
	assign stat.fill_last = (fidx_q == IDX_W'(RAMP_STEPS - 1));
	assign stat.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ms_q   <= 16'd500;
			mm_per_turn_q <= 16'd2000;
			ppt_cfg_q     <= 8'd1;
		end else if (cfg_we) begin
			if (cfg_index == CFG_WINDOW_MS) window_ms_q <= cfg_data;
			if (cfg_index == CFG_MM_PER_TURN) mm_per_turn_q <= cfg_data;
			if (cfg_index == CFG_PULSES_PER_TURN) ppt_cfg_q <= cfg_data[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wtime_q      <= '0;
			wpulses_q    <= '0;
			odo_q        <= '0;
			prev_q       <= '0;
			cur_q        <= '0;
			res_closed_q <= 1'b0;
			res_wspeed_q <= '0;
			res_valid_q  <= 1'b0;
			res_shown_q  <= '0;
			out_valid_q  <= 1'b0;
			for (int k = 0; k < RAMP_STEPS; k++) begin
				store_q[k] <= '0;
			end
		end else begin
			if (cmd.accept) begin
				res_closed_q <= 1'b0;
				res_wspeed_q <= '0;
				res_valid_q  <= 1'b0;
				res_shown_q  <= '0;
				if (func == FUNC_MEASURE) begin
					wtime_q   <= wtime_q + {16'd0, elapsed_ms};
					wpulses_q <= wpulses_q + {16'd0, pulse_delta};
				end
				if ((func == FUNC_SEND) && send_ok) begin
					res_valid_q <= 1'b1;
					res_shown_q <= store_q[cur_q[IDX_W-1:0]];
					cur_q       <= cur_q + 1'b1;
				end
			end
			if (cmd.close) begin
				wtime_q   <= '0;
				wpulses_q <= '0;
			end
			if (cmd.spd_prep) begin
				odo_q <= odo_q + num_q[31:0];
			end
			if (cmd.fill_init) begin
				res_closed_q <= 1'b1;
				res_wspeed_q <= spd_final;
				prev_q       <= spd_final;
				cur_q        <= '0;
			end
			if (cmd.fill_step) begin
				store_q[fidx_q] <= inc_q ? (base_q + ramp_step) : (base_q - ramp_step);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= func;
		end
		if (cmd.close) begin
			tlat_q <= wtime_q;
			ppt_q  <= (ppt_cfg_q == 8'd0) ? 8'd1 : ppt_cfg_q;
			num_q  <= PROD_W'(wpulses_q * mm_per_turn_q);
			rem_q  <= '0;
			dcnt_q <= '0;
		end
		if (cmd.dist_step) begin
			num_q  <= num_d;
			rem_q  <= rem_d;
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.spd_prep) begin
			// distance * 36 and time * 10 as shift-and-add
			nsp_q <= ({{(NUM_W-PROD_W){1'b0}}, num_q} << 5)
				+ ({{(NUM_W-PROD_W){1'b0}}, num_q} << 2);
			den_q <= ({4'd0, tlat_q} << 3) + ({4'd0, tlat_q} << 1);
			if (func_q == FUNC_TIMEOUT) begin
				ovr_q     <= 1'b1;
				ovr_val_q <= '0;
			end else if (tlat_q == 32'd0) begin
				ovr_q     <= 1'b1;
				ovr_val_q <= (num_q != '0) ? SPEED_MAX : '0;
			end else begin
				ovr_q     <= 1'b0;
				ovr_val_q <= '0;
			end
		end
		if (cmd.sat) begin
			// A quotient of 1024 or more cannot come out of ten bits.
			if (!ovr_q && (nsp_q >= {{(NUM_W-DEN_W-QBITS){1'b0}}, den_q, {QBITS{1'b0}}})) begin
				ovr_q     <= 1'b1;
				ovr_val_q <= SPEED_MAX;
			end
			dsh_q  <= {den_q, {(QBITS-1){1'b0}}};
			q_q    <= '0;
			qcnt_q <= '0;
		end
		if (cmd.spd_step) begin
			if (nsp_q >= {{(NUM_W-DEN_W-QBITS+1){1'b0}}, dsh_q}) begin
				nsp_q <= nsp_q - {{(NUM_W-DEN_W-QBITS+1){1'b0}}, dsh_q};
				q_q   <= {q_q[QBITS-2:0], 1'b1};
			end else begin
				q_q   <= {q_q[QBITS-2:0], 1'b0};
			end
			dsh_q  <= dsh_q >> 1;
			qcnt_q <= qcnt_q + 1'b1;
		end
		if (cmd.fill_init) begin
			base_q <= prev_q;
			inc_q  <= (spd_final > prev_q);
			fidx_q <= '0;
			if (spd_final > prev_q) begin
				dmag_q <= spd_final - prev_q;
				acc_q  <= ACC_W'(spd_final - prev_q);
			end else begin
				dmag_q <= prev_q - spd_final;
				acc_q  <= '0;
			end
		end
		if (cmd.fill_step) begin
			acc_q  <= acc_q + ACC_W'(dmag_q);
			fidx_q <= fidx_q + 1'b1;
		end
		if (cmd.emit) begin
			out_closed_q <= res_closed_q;
			out_wspeed_q <= res_wspeed_q;
			out_svalid_q <= res_valid_q;
			out_shown_q  <= res_shown_q;
			out_odo_q    <= odo_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign window_closed = out_closed_q;
	assign window_speed  = out_wspeed_q;
	assign shown_valid   = out_svalid_q;
	assign shown_speed   = out_shown_q;
	assign odometer_mm   = out_odo_q;

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= CUR_W'(RAMP_STEPS))
		else $error("send cursor ran past the ramp store");

	a_fill_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_init |=> (cur_q == '0) && (prev_q == res_wspeed_q) && res_closed_q)
		else $error("ramp fill did not rewind the cursor or record the speed");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_closed_q |-> (res_wspeed_q <= SPEED_MAX))
		else $error("window speed above saturation limit");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dist_step |-> (ppt_q != 8'd0) && (rem_q < ppt_q))
		else $error("distance divider remainder out of range");

endmodule

[rtl/core/wheel_speed_ramp_meter.sv]
// A request that closes a window passes through distance division, speed division and ramp
// fill before its result is loaded into the output register; other requests go from the
// decision straight to the output register. The block takes one request at a time and
// accepts no new request until the previous result has moved into the output register,
// so it stalls while an earlier result still waits there.
// Reset (arst_n low) clears totals, odometer, ramp store and cursor and loads default config.
module wheel_speed_ramp_meter (
	input  logic              clk,
	input  logic              arst_n,
	wsrm_in_if.sink           in_ch,
	wsrm_out_if.source        out_ch,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import wsrm_pkg::*;

	wsrm_cmd_t  cmd;
	wsrm_stat_t stat;
	logic       in_ready;

	assign in_ch.ready = in_ready;

	wsrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	wsrm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (in_ch.func),
		.elapsed_ms    (in_ch.elapsed_ms),
		.pulse_delta   (in_ch.pulse_delta),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.window_closed (out_ch.window_closed),
		.window_speed  (out_ch.window_speed),
		.shown_valid   (out_ch.shown_valid),
		.shown_speed   (out_ch.shown_speed),
		.odometer_mm   (out_ch.odometer_mm)
	);

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import wsrm_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int KMH_NUM       = 36;
	localparam int KMH_DEN       = 10;
	localparam int CLOSE_LATENCY = 50;
	localparam int QUIET_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 400;
	localparam int PRINT_CAP     = 40;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] elapsed_ms;
		logic [15:0] pulse_delta;
	} meter_req_t;

	typedef struct packed {
		logic             closed;
		logic [SPD_W-1:0] window_kmh;
		logic             shown_ok;
		logic [SPD_W-1:0] shown_kmh;
		logic [31:0]      odo;
	} reading_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_WINDOW_MS;
	logic [15:0] cfg_data = '0;

	wsrm_in_if  in_ch ();
	wsrm_out_if out_ch ();

	wheel_speed_ramp_meter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predicted register contents and block state.
	logic [15:0]      win_len = 16'd500;
	logic [15:0]      mm_turn = 16'd2000;
	logic [7:0]       ppt = 8'd1;
	logic [31:0]      acc_time = '0;
	logic [31:0]      acc_pulses = '0;
	logic [31:0]      odo_mm = '0;
	logic [SPD_W-1:0] last_kmh = '0;
	logic [SPD_W-1:0] ramp_vals [RAMP_STEPS];
	int unsigned      ramp_pos = 0;

	meter_req_t  pending_reqs [$];
	reading_t    due_readings [$];
	meter_req_t  next_req;
	reading_t    want_rd;
	int unsigned queued_total = 0;
	int unsigned sent_total = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic        recv_hold = 1'b0;
	event        hold_go;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.func = FUNC_MEASURE;
		in_ch.elapsed_ms = '0;
		in_ch.pulse_delta = '0;
		out_ch.ready = 1'b0;
		for (int k = 0; k < RAMP_STEPS; k++)
			ramp_vals[k] = '0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got)
			report_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
	endtask

	task automatic close_window(input logic timed_out, output logic [SPD_W-1:0] kmh);
		logic [63:0] dist_mm;
		logic [63:0] raw;
		int unsigned from_kmh;
		int unsigned to_kmh;
		dist_mm = (64'(acc_pulses) * 64'(mm_turn)) / ((ppt == 8'd0) ? 64'd1 : 64'(ppt));
		odo_mm = odo_mm + dist_mm[31:0];
		if (timed_out)
			raw = '0;
		else if (acc_time == 0)
			raw = (dist_mm != 0) ? 64'(SPEED_MAX) : 64'd0;
		else
			raw = dist_mm * 64'(KMH_NUM) / 64'(KMH_DEN) / 64'(acc_time);
		if (raw > 64'(SPEED_MAX))
			raw = 64'(SPEED_MAX);
		kmh = raw[SPD_W-1:0];
		acc_time = '0;
		acc_pulses = '0;
		// The ramp runs from the last shown target toward the new speed.
		from_kmh = last_kmh;
		to_kmh = kmh;
		for (int k = 0; k < RAMP_STEPS; k++) begin
			if (to_kmh == from_kmh)
				ramp_vals[k] = SPD_W'(to_kmh);
			else if (to_kmh > from_kmh)
				ramp_vals[k] = SPD_W'(from_kmh + (to_kmh - from_kmh) * (k + 1) / RAMP_STEPS);
			else
				ramp_vals[k] = SPD_W'(from_kmh - (from_kmh - to_kmh) * k / RAMP_STEPS);
		end
		last_kmh = kmh;
		ramp_pos = 0;
	endtask

	task automatic predict_reading(input meter_req_t req);
		reading_t rd;
		rd = '0;
		case (req.func)
			FUNC_MEASURE: begin
				acc_time = acc_time + 32'(req.elapsed_ms);
				acc_pulses = acc_pulses + 32'(req.pulse_delta);
				if (acc_time >= 32'(win_len)) begin
					rd.closed = 1'b1;
					close_window(1'b0, rd.window_kmh);
				end
			end
			FUNC_TIMEOUT: begin
				rd.closed = 1'b1;
				close_window(1'b1, rd.window_kmh);
			end
			FUNC_SEND: begin
				if (ramp_pos < RAMP_STEPS) begin
					rd.shown_ok = 1'b1;
					rd.shown_kmh = ramp_vals[ramp_pos];
					ramp_pos++;
				end
			end
			default: begin
			end
		endcase
		rd.odo = odo_mm;
		due_readings.push_back(rd);
	endtask

	// Request driver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				predict_reading({in_ch.func, in_ch.elapsed_ms, in_ch.pulse_delta});
				sent_total++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = pending_reqs.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.func <= next_req.func;
					in_ch.elapsed_ms <= next_req.elapsed_ms;
					in_ch.pulse_delta <= next_req.pulse_delta;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (due_readings.size() == 0) begin
					report_mismatch("result arrived with nothing expected");
				end else begin
					want_rd = due_readings.pop_front();
					check_field("window_closed", want_rd.closed, out_ch.window_closed);
					check_field("window_speed", want_rd.window_kmh, out_ch.window_speed);
					check_field("shown_valid", want_rd.shown_ok, out_ch.shown_valid);
					check_field("shown_speed", want_rd.shown_kmh, out_ch.shown_speed);
					check_field("odometer_mm", want_rd.odo, out_ch.odometer_mm);
				end
			end
			out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Long receiver hold-off so the block backs up into its input.
	initial begin
		forever begin
			@(hold_go);
			@(posedge clk);
			recv_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			recv_hold <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic push_req(input logic [1:0] fn, input logic [15:0] el,
		input logic [15:0] pd);
		pending_reqs.push_back({fn, el, pd});
		queued_total++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_WINDOW_MS:       win_len = val;
			CFG_MM_PER_TURN:     mm_turn = val;
			CFG_PULSES_PER_TURN: ppt = val[7:0];
			default: begin
			end
		endcase
	endtask

	task automatic wait_drained();
		while (sent_total != queued_total || due_readings.size() != 0)
			@(posedge clk);
	endtask

	// Mostly measurements that fill windows, with bursts of send ticks that drain
	// the ramp and sometimes run past its end, plus timeouts and unused selectors.
	task automatic queue_random(input int count);
		int unsigned span;
		int unsigned el;
		int unsigned pd;
		int unsigned pick;
		int unsigned burst;
		int made;
		made = 0;
		span = (win_len == 0) ? 1 : win_len;
		while (made < count) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				case ($urandom_range(3))
					0: el = $urandom_range(65535);
					1: el = $urandom_range(span / 8);
					default: el = $urandom_range(span * 3 / 4);
				endcase
				case ($urandom_range(4))
					0: pd = 0;
					1: pd = $urandom_range(65535);
					2: pd = $urandom_range(300);
					default: pd = $urandom_range(20);
				endcase
				push_req(FUNC_MEASURE, 16'(el), 16'(pd));
				made++;
			end else if (pick < 65) begin
				push_req(FUNC_TIMEOUT, 16'($urandom), 16'($urandom));
				made++;
			end else if (pick < 70) begin
				push_req(FUNC_UNUSED, 16'($urandom), 16'($urandom));
				made++;
			end else begin
				burst = $urandom_range(1, RAMP_STEPS + 2);
				repeat (burst) push_req(FUNC_SEND, 16'($urandom), 16'($urandom));
				made += burst;
			end
		end
	endtask

	task automatic run_phase(input logic [15:0] win, input logic [15:0] mm,
		input logic [15:0] pulses, input int unsigned idle, input int unsigned stall,
		input int count, input logic with_hold);
		write_reg(CFG_WINDOW_MS, win);
		write_reg(CFG_MM_PER_TURN, mm);
		write_reg(CFG_PULSES_PER_TURN, pulses);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		queue_random(count);
		if (with_hold)
			-> hold_go;
		wait_drained();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: window 500 ms, 2000 mm per turn, one pulse per turn.
		push_req(FUNC_SEND, 16'h0000, 16'h0000);
		push_req(FUNC_MEASURE, 16'h0000, 16'h0000);
		push_req(FUNC_MEASURE, 16'hFFFF, 16'hFFFF);
		repeat (RAMP_STEPS + 1) push_req(FUNC_SEND, 16'h0000, 16'h0000);
		push_req(FUNC_UNUSED, 16'hFFFF, 16'hFFFF);
		push_req(FUNC_MEASURE, 16'd10, 16'd1000);
		push_req(FUNC_TIMEOUT, 16'hFFFF, 16'hFFFF);
		push_req(FUNC_SEND, 16'hFFFF, 16'hFFFF);
		push_req(FUNC_SEND, 16'hFFFF, 16'hFFFF);
		push_req(FUNC_MEASURE, 16'd499, 16'd1);
		push_req(FUNC_MEASURE, 16'd1, 16'd0);
		push_req(FUNC_MEASURE, 16'd500, 16'd7);
		push_req(FUNC_MEASURE, 16'd500, 16'd7);
		push_req(FUNC_SEND, 16'h0000, 16'h0000);
		push_req(FUNC_TIMEOUT, 16'h0000, 16'h0000);
		wait_drained();

		// A zero window closes on every measurement, including zero elapsed time.
		// Only the low byte of the pulse count register counts, so this sets zero.
		write_reg(CFG_WINDOW_MS, 16'd0);
		write_reg(CFG_MM_PER_TURN, 16'hFFFF);
		write_reg(CFG_PULSES_PER_TURN, 16'h0100);
		push_req(FUNC_MEASURE, 16'd0, 16'd0);
		push_req(FUNC_MEASURE, 16'd0, 16'd5);
		push_req(FUNC_MEASURE, 16'd3, 16'd0);
		push_req(FUNC_SEND, 16'd0, 16'd0);
		wait_drained();

		run_phase(16'd0, 16'hFFFF, 16'h0100, 85, 0, 150, 1'b0);
		run_phase(16'hFFFF, 16'd1, 16'd255, 0, 85, 200, 1'b0);
		run_phase(16'd1000, 16'd2100, 16'd4, 31, 31, 250, 1'b1);
		run_phase(16'd250, 16'd1800, 16'd2, 0, 0, 250, 1'b0);
		run_phase(16'd1, 16'hFFFF, 16'd1, 85, 0, 150, 1'b0);
		run_phase(16'd500, 16'd0, 16'd0, 0, 85, 60, 1'b0);
		run_phase(16'd500, 16'd2000, 16'd1, 31, 31, 170, 1'b0);

		repeat (CLOSE_LATENCY + 10) @(posedge clk);
		if (mismatch_count == 0 && due_readings.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/core/wsrm_pkg.sv
rtl/core/wsrm_if.sv
rtl/core/wsrm_ctrl.sv
rtl/core/wsrm_datapath.sv
rtl/core/wheel_speed_ramp_meter.sv
bench/testbench.sv
